/* rtl/gfq_pkg.sv */
// Package for the polygon geofence query core.
// Holds the transaction payload types, the back-end state type and shared constants.
// No dependencies.
`default_nettype none
package gfq_pkg;

  localparam int FIELD_W  = 32;
  localparam int IDX_W    = 6;
  localparam int VCOUNT_W = 7;
  localparam int DIST_W   = 32;
  localparam int SQ_W     = 64;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [IDX_W-1:0]           vertex_index;
    logic signed [FIELD_W-1:0]  coord_x;
    logic signed [FIELD_W-1:0]  coord_y;
  } in_item_t;

  typedef struct packed {
    logic              inside_res;
    logic [DIST_W-1:0] min_distance;
    logic              empty_polygon;
  } out_item_t;

  typedef struct packed {
    logic back_idle;
    logic q_empty;
    logic q_full;
  } gfq_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_PREV,
    ST_LD_CUR,
    ST_MUL,
    ST_CLASS,
    ST_SQR,
    ST_SATCHK,
    ST_DIV,
    ST_UPD,
    ST_SQRT
  } back_state_e;

endpackage
`default_nettype wire

/* rtl/polygon_geofence_query_core.sv */
// Top level of the polygon geofence query core.
// Depends on gfq_pkg, gfq_ram, gfq_fifo, gfq_front, gfq_back (and gfq_isqrt).
//
// Usage: the input channel (in_valid_i/in_ready_o/in_item_i) carries two kinds
// of transaction. A vertex write stores one vertex in the table and yields no
// result; a query yields exactly one transaction on the output channel
// (out_valid_o/out_ready_i/out_item_o) with the inside flag and the distance.
// The configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) sets the
// number of vertices in use; it is always ready. It is to be written only while
// idle; the block itself does not enforce this. The back end walks a query edge
// by edge: each edge costs a table load, the shared multiplier, a classification
// and an update, plus, when the point projects inside the segment, a bit-serial
// squaring of the cross product, a range check and, unless that check saturates,
// a 64-step restoring division. A final square root follows. An empty polygon
// skips the edge walk. The back end works on one query at a time and takes no
// new query until the last is through. Queries are queued two deep, so the
// front keeps accepting while the back is busy or a result waits. A vertex write
// is held off until every earlier query has left the back end. If the receiver
// stalls, the result waits in the output register and the back end takes no new
// query. Reset clears the vertex count and all control state; the vertex table
// is not cleared.
`default_nettype none
module polygon_geofence_query_core #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gfq_pkg::in_item_t             in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gfq_pkg::out_item_t                 out_item_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gfq_pkg::VCOUNT_W-1:0]  cfg_data_i
);
  import gfq_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [VCOUNT_W-1:0]      vcount_q;
  logic [NW-1:0]            n_eff;
  gfq_status_t              status;
  logic                     push, q_valid, q_pop, q_full, q_empty, back_idle;
  logic [2*COORD_WIDTH-1:0] point, q_point, rd_data;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr, rd_addr;

  // Configuration register: a count above the table size acts as the table size.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_valid_i) begin
      vcount_q <= cfg_data_i;
    end
  end
  assign n_eff = (32'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);

  assign status.back_idle = back_idle;
  assign status.q_empty   = q_empty;
  assign status.q_full    = q_full;

  gfq_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .in_item_i  (in_item_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .push_o     (push),
    .point_o    (point),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr)
  );

  // Vertex table: x in the upper half of each word, y in the lower half.
  gfq_ram #(
    .W     (2 * COORD_WIDTH),
    .DEPTH (MAX_VERTICES)
  ) u_vtab (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (point),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  gfq_fifo #(
    .W (2 * COORD_WIDTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (point),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_point),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  gfq_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_point),
    .q_pop_o     (q_pop),
    .n_i         (n_eff),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .idle_o      (back_idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

/* rtl/gfq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gfq_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/gfq_fifo.sv */
// Two-entry queue that carries query points from the front end to the back end.
// No dependencies.
`default_nettype none
module gfq_fifo #(
  parameter int W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = !empty_o;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/gfq_front.sv */
// Front end: accepts input transactions, writes vertices, queues query points.
// Depends on gfq_pkg.
`default_nettype none
module gfq_front #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 32,
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  wire gfq_pkg::in_item_t    in_item_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire gfq_pkg::gfq_status_t status_i,
  output logic                      push_o,
  output logic [2*COORD_WIDTH-1:0]  point_o,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o
);
  import gfq_pkg::*;

  logic                          is_query;
  logic signed [COORD_WIDTH-1:0] cx, cy;

  // Coordinates are taken as COORD_WIDTH-bit two's complement values.
  assign cx = COORD_WIDTH'(in_item_i.coord_x);
  assign cy = COORD_WIDTH'(in_item_i.coord_y);
  assign point_o = {cx, cy};

  assign is_query = (in_item_i.action == ACT_QUERY);

  // A vertex write waits until no query is queued or in flight.
  assign in_ready_o = is_query ? !status_i.q_full : (status_i.q_empty && status_i.back_idle);

  assign push_o    = in_valid_i && in_ready_o && is_query;
  assign wr_en_o   = in_valid_i && in_ready_o && !is_query &&
                     (32'(in_item_i.vertex_index) < MAX_VERTICES);
  assign wr_addr_o = AW'(in_item_i.vertex_index);

endmodule
`default_nettype wire

/* rtl/gfq_isqrt.sv */
// Iterative 64-bit integer square root, two radicand bits per cycle.
// Depends on gfq_pkg.
`default_nettype none
module gfq_isqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [gfq_pkg::SQ_W-1:0]   value_i,
  output logic                            done_o,
  output logic [gfq_pkg::DIST_W-1:0]      root_o
);
  import gfq_pkg::*;

  logic            busy_q;
  logic [4:0]      cnt_q;
  logic [SQ_W-1:0] v_q, res_q, bit_q;
  logic [SQ_W-1:0] trial;
  logic            ge;

  assign trial  = res_q + bit_q;
  assign ge     = (v_q >= trial);
  assign root_o = res_q[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule
`default_nettype wire

/* rtl/gfq_back.sv */
// Back end: walks the polygon edges for one query, keeps crossing parity and the
// minimum squared distance, then takes the square root. Depends on gfq_pkg, gfq_isqrt.
`default_nettype none
module gfq_back #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 32,
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int NW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  input  wire logic [2*COORD_WIDTH-1:0]   q_data_i,
  output logic                            q_pop_o,
  input  wire logic [NW-1:0]              n_i,
  output logic [AW-1:0]                   rd_addr_o,
  input  wire logic [2*COORD_WIDTH-1:0]   rd_data_i,
  output logic                            idle_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output gfq_pkg::out_item_t              out_item_o
);
  import gfq_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int D    = CW + 1;
  localparam int PW   = 2 * D;
  localparam int LW   = PW + 1;
  localparam int BW   = LW + 2;
  localparam int SW   = (BW > SQ_W + 1) ? BW : SQ_W + 1;
  localparam int RW   = (4 * D + 2 > LW + SQ_W) ? 4 * D + 2 : LW + SQ_W;
  localparam int CNTW = ($clog2(LW + 1) > 6) ? $clog2(LW + 1) : 6;

  back_state_e state_q, state_d;

  logic signed [CW-1:0] px_q, py_q, prevx_q, prevy_q, rx, ry;
  logic [NW-1:0]        n_q;
  logic [AW-1:0]        idx_q;
  logic signed [D-1:0]  vx_q, vy_q, wx_q, wy_q, mul_a, mul_b;
  logic                 abv_i_q, abv_j_q;
  logic signed [PW-1:0] prod, prod_q;
  logic signed [LW-1:0] pe, len2_q, dot_q, cr_q;
  logic signed [LW-1:0] wsq_q;
  logic signed [BW-1:0] bsq;
  logic [SW-1:0]        wsq_w, bsq_w;
  logic [SQ_W-1:0]      wsq_sat, bsq_sat, best_q, cand_q, best_new, quo_q;
  logic [LW-1:0]        len2_u, cr_abs, mr_q;
  logic [RW-1:0]        rem_q, dv_q, mc_q, len2_hi;
  logic                 div_ge;
  logic [CNTW-1:0]      cnt_q;
  logic                 inside_q, crosses, last_edge;
  logic                 out_free, pop, sqrt_start, sqrt_done;
  logic [DIST_W-1:0]    root;
  out_item_t            out_item_q;
  logic                 out_valid_q;

  assign rx = rd_data_i[2*CW-1:CW];
  assign ry = rd_data_i[CW-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = (state_q == ST_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = pop;
  assign idle_o   = (state_q == ST_IDLE);
  assign last_edge = (idx_q == AW'(n_q - 1'b1));

  // Shared multiplier: one product per cycle, registered before accumulation.
  always_comb begin
    case (cnt_q)
      0:       begin mul_a = vx_q; mul_b = vx_q; end
      1:       begin mul_a = vy_q; mul_b = vy_q; end
      2:       begin mul_a = wx_q; mul_b = vx_q; end
      3:       begin mul_a = wy_q; mul_b = vy_q; end
      4:       begin mul_a = wx_q; mul_b = vy_q; end
      5:       begin mul_a = wy_q; mul_b = vx_q; end
      6:       begin mul_a = wx_q; mul_b = wx_q; end
      7:       begin mul_a = wy_q; mul_b = wy_q; end
      default: begin mul_a = '0;   mul_b = '0;   end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign pe   = LW'(prod_q);

  // Squared distance to the far end: |w - v|^2 = |w|^2 - 2 w.v + |v|^2.
  assign bsq     = BW'(wsq_q) - (BW'(dot_q) <<< 1) + BW'(len2_q);
  assign wsq_w   = SW'($unsigned(wsq_q));
  assign bsq_w   = SW'($unsigned(bsq));
  assign wsq_sat = ((wsq_w >> SQ_W) != '0) ? '1 : wsq_w[SQ_W-1:0];
  assign bsq_sat = ((bsq_w >> SQ_W) != '0) ? '1 : bsq_w[SQ_W-1:0];

  assign len2_u  = $unsigned(len2_q);
  assign len2_hi = RW'(len2_u) << SQ_W;
  assign cr_abs  = cr_q[LW-1] ? $unsigned(-cr_q) : $unsigned(cr_q);
  assign div_ge  = (rem_q >= dv_q);

  // The rightward ray crosses the edge when the endpoints straddle the point's
  // row and the point lies left of the edge, judged by the cross product sign.
  assign crosses = (abv_i_q != abv_j_q) && ((vy_q > 0) ? (cr_q < 0) : (cr_q > 0));

  assign best_new   = (cand_q < best_q) ? cand_q : best_q;
  assign sqrt_start = (state_q == ST_UPD) && last_edge;

  always_comb begin
    rd_addr_o = idx_q;
    case (state_q)
      ST_IDLE:    rd_addr_o = AW'(n_i - 1'b1);
      ST_LD_PREV: rd_addr_o = '0;
      ST_UPD:     rd_addr_o = idx_q + 1'b1;
      default:    rd_addr_o = idx_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop && (n_i != '0)) begin
          state_d = ST_LD_PREV;
        end
      end
      ST_LD_PREV: state_d = ST_LD_CUR;
      ST_LD_CUR:  state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == CNTW'(8)) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if ((len2_q == '0) || (dot_q < 0) || (dot_q > len2_q)) begin
          state_d = ST_UPD;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (cnt_q == '0) begin
          state_d = ST_SATCHK;
        end
      end
      ST_SATCHK: state_d = (rem_q >= len2_hi) ? ST_UPD : ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD:  state_d = last_edge ? ST_SQRT : ST_LD_CUR;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((pop && (n_i == '0)) || ((state_q == ST_SQRT) && sqrt_done)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        px_q     <= q_data_i[2*CW-1:CW];
        py_q     <= q_data_i[CW-1:0];
        n_q      <= n_i;
        best_q   <= '1;
        inside_q <= 1'b0;
        if (pop && (n_i == '0)) begin
          out_item_q.inside_res    <= 1'b0;
          out_item_q.min_distance  <= '1;
          out_item_q.empty_polygon <= 1'b1;
        end
      end
      ST_LD_PREV: begin
        prevx_q <= rx;
        prevy_q <= ry;
        idx_q   <= '0;
      end
      ST_LD_CUR: begin
        vx_q    <= D'(prevx_q) - D'(rx);
        vy_q    <= D'(prevy_q) - D'(ry);
        wx_q    <= D'(px_q) - D'(rx);
        wy_q    <= D'(py_q) - D'(ry);
        abv_i_q <= (ry > py_q);
        abv_j_q <= (prevy_q > py_q);
        prevx_q <= rx;
        prevy_q <= ry;
        cnt_q   <= '0;
      end
      ST_MUL: begin
        prod_q <= prod;
        cnt_q  <= cnt_q + 1'b1;
        case (cnt_q)
          1:       len2_q <= pe;
          2:       len2_q <= len2_q + pe;
          3:       dot_q  <= pe;
          4:       dot_q  <= dot_q + pe;
          5:       cr_q   <= pe;
          6:       cr_q   <= cr_q - pe;
          7:       wsq_q  <= pe;
          8:       wsq_q  <= wsq_q + pe;
          default: ;
        endcase
      end
      ST_CLASS: begin
        inside_q <= inside_q ^ crosses;
        if ((len2_q == '0) || (dot_q < 0)) begin
          cand_q <= wsq_sat;
        end else if (dot_q > len2_q) begin
          cand_q <= bsq_sat;
        end
        mc_q  <= RW'(cr_abs);
        mr_q  <= cr_abs;
        rem_q <= '0;
        cnt_q <= CNTW'(LW - 1);
      end
      ST_SQR: begin
        if (mr_q[0]) begin
          rem_q <= rem_q + mc_q;
        end
        mc_q  <= mc_q << 1;
        mr_q  <= mr_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      ST_SATCHK: begin
        cand_q <= '1;
        dv_q   <= RW'(len2_u) << (SQ_W - 1);
        quo_q  <= '0;
        cnt_q  <= CNTW'(SQ_W - 1);
      end
      ST_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dv_q;
        end
        quo_q <= {quo_q[SQ_W-2:0], div_ge};
        dv_q  <= dv_q >> 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cand_q <= {quo_q[SQ_W-2:0], div_ge};
        end
      end
      ST_UPD: begin
        best_q <= best_new;
        idx_q  <= idx_q + 1'b1;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          out_item_q.inside_res    <= inside_q;
          out_item_q.min_distance  <= root;
          out_item_q.empty_polygon <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  gfq_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (best_new),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SQRT) && sqrt_done) |-> !out_valid_q)
    else $error("result register overwritten");

  // An empty polygon answers in the cycle after the query is taken.
  a_empty_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (n_i == '0)) |=> (out_valid_q && out_item_q.empty_polygon))
    else $error("empty polygon result missing");

  // The long division never needs a quotient bit beyond the 64 computed.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((rem_q >> 1) < dv_q || dv_q == '0))
    else $error("division remainder out of range");

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for polygon_geofence_query_core.
// Depends on gfq_pkg and the core; predicts each query with exact wide arithmetic.
// A directed table comes first, then random polygons and queries under random stalls.
`default_nettype none
module tb;
  import gfq_pkg::*;

  localparam int NUM_ENTRIES  = 64;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_FROM   = 1250;
  localparam int DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 100000000;

  // Wide signed type: every product and square of 33-bit differences fits with room.
  typedef logic signed [255:0] wide_t;

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_ready_o;
  in_item_t     in_item_i;
  logic         out_valid_o;
  logic         out_ready_i;
  out_item_t    out_item_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [VCOUNT_W-1:0] cfg_data_i;

  polygon_geofence_query_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the vertex table and of the vertex count register.
  longint       shadow_x [NUM_ENTRIES];
  longint       shadow_y [NUM_ENTRIES];
  logic [6:0]   shadow_count;

  // Answers still owed by the core, oldest first.
  out_item_t    pending_answers [$];

  longint       cycles;
  int           errors;
  int           items_sent;
  int           queries_sent;
  int           answers_seen;
  int           saturated_seen;
  int           inside_seen;
  bit           quiet;

  // One row of the directed table: either a register write or an input transaction,
  // optionally with the answer typed in by hand.
  typedef struct {
    bit          is_cfg;
    logic [6:0]  cfg_val;
    in_item_t    item;
    bit          has_answer;
    out_item_t   answer;
  } row_t;

  row_t directed_rows [$];

  // ---------------------------------------------------------------------------
  // Clock, cycle counter and the global timeout.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i  = 1'b0;
    cycles = 0;
    forever begin
      #5 clk_i = ~clk_i;
      if (clk_i) cycles++;
    end
  end

  initial begin
    wait (cycles > CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor of one query over the shadow table.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] clip64(input wide_t v);
    if ((v >>> 64) != 0) return '1;
    return v[63:0];
  endfunction

  // Floored squared distance in Q16 from the point to one segment, projection clamped.
  function automatic logic [63:0] segment_dist2(input longint px, input longint py,
                                                input longint ax, input longint ay,
                                                input longint bx, input longint by);
    wide_t vx, vy, wx, wy, ux, uy, len2, dot, cr, quot;
    vx = bx - ax;
    vy = by - ay;
    wx = px - ax;
    wy = py - ay;
    ux = px - bx;
    uy = py - by;
    len2 = vx * vx + vy * vy;
    dot  = wx * vx + wy * vy;
    if (len2 == 0 || dot < 0) return clip64(wx * wx + wy * wy);
    if (dot > len2) return clip64(ux * ux + uy * uy);
    cr   = wx * vy - wy * vx;
    quot = (cr * cr) / len2;
    return clip64(quot);
  endfunction

  // Does the rightward ray from the point cross the edge from vertex i to vertex j?
  function automatic bit ray_crosses(input longint tx, input longint ty,
                                     input longint xi, input longint yi,
                                     input longint xj, input longint yj);
    wide_t lhs, rhs, dy;
    if ((yi > ty) == (yj > ty)) return 1'b0;
    dy  = yj - yi;
    lhs = wide_t'(tx - xi) * dy;
    rhs = wide_t'(xj - xi) * wide_t'(ty - yi);
    return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rem, res, bitv;
    rem  = v;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t geofence_answer(input longint px, input longint py);
    out_item_t   r;
    int          n, i, j;
    bit          parity;
    logic [63:0] best, d;
    n      = (shadow_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(shadow_count);
    parity = 1'b0;
    best   = '1;
    j      = n - 1;
    for (i = 0; i < n; i++) begin
      if (ray_crosses(px, py, shadow_x[i], shadow_y[i], shadow_x[j], shadow_y[j]))
        parity = ~parity;
      d = segment_dist2(px, py, shadow_x[i], shadow_y[i], shadow_x[j], shadow_y[j]);
      if (d < best) best = d;
      j = i;
    end
    r.inside_res    = parity;
    r.min_distance  = (n == 0) ? '1 : 32'(floor_sqrt(best));
    r.empty_polygon = (n == 0);
    return r;
  endfunction

  function automatic in_item_t make_item(input logic act, input int idx,
                                         input int x, input int y);
    in_item_t it;
    it.action       = act;
    it.vertex_index = idx[IDX_W-1:0];
    it.coord_x      = x;
    it.coord_y      = y;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel driver. Handshakes are sampled at the falling edge, where every
  // signal is settled, and take effect at the following rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit has_answer, input out_item_t ans);
    int gap;
    bit taken;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    items_sent++;
    if (it.action == ACT_QUERY) begin
      queries_sent++;
      if (has_answer) pending_answers.push_back(ans);
      else pending_answers.push_back(geofence_answer(longint'(it.coord_x),
                                                     longint'(it.coord_y)));
    end else begin
      shadow_x[it.vertex_index] = longint'(it.coord_x);
      shadow_y[it.vertex_index] = longint'(it.coord_y);
    end
  endtask

  // Holds the sender off until every owed answer has arrived, then lets the core
  // finish any vertex write still in flight.
  task automatic drain_core();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [6:0] value);
    bit taken;
    drain_core();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i  <= 1'b0;
    shadow_count = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, and a checker that compares every accepted
  // result transaction with the oldest owed answer.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : result_check
    out_item_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        answers_seen++;
        if (out_item_o.min_distance == '1) saturated_seen++;
        if (out_item_o.inside_res) inside_seen++;
        if (pending_answers.size() == 0) begin
          $error("result transaction with no query waiting: %p", out_item_o);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (out_item_o.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, actual %0d", want.inside_res,
                   out_item_o.inside_res);
            errors++;
          end
          if (out_item_o.min_distance !== want.min_distance) begin
            $error("min_distance: expected %0h, actual %0h", want.min_distance,
                   out_item_o.min_distance);
            errors++;
          end
          if (out_item_o.empty_polygon !== want.empty_polygon) begin
            $error("empty_polygon: expected %0d, actual %0d", want.empty_polygon,
                   out_item_o.empty_polygon);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  function automatic void add_cfg(input logic [6:0] v);
    row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_item(input logic act, input int idx, input int x, input int y);
    row_t r;
    r = '{default: '0};
    r.item = make_item(act, idx, x, y);
    directed_rows.push_back(r);
  endfunction

  function automatic void add_known(input int x, input int y, input logic ins,
                                   input logic [31:0] distance, input logic empty);
    row_t r;
    r = '{default: '0};
    r.item = make_item(ACT_QUERY, 0, x, y);
    r.has_answer = 1'b1;
    r.answer.inside_res    = ins;
    r.answer.min_distance  = distance;
    r.answer.empty_polygon = empty;
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    // Right after reset no vertex is in use, so the answer is the empty sentinel.
    add_known(0, 0, 1'b0, 32'hFFFF_FFFF, 1'b1);
    // A 10 m square; its center lies 5 m from every side.
    add_item(ACT_WRITE, 0, 0, 0);
    add_item(ACT_WRITE, 1, 2560, 0);
    add_item(ACT_WRITE, 2, 2560, 2560);
    add_item(ACT_WRITE, 3, 0, 2560);
    add_cfg(7'd4);
    add_known(1280, 1280, 1'b1, 32'd1280, 1'b0);
    add_known(5120, 1280, 1'b0, 32'd2560, 1'b0);
    add_item(ACT_QUERY, 0, 0, 0);
    add_item(ACT_QUERY, 0, 2560, 1280);
    // A zero-length edge: vertex 3 on top of vertex 2.
    add_item(ACT_WRITE, 3, 2560, 2560);
    add_item(ACT_QUERY, 0, 3000, 3000);
    add_item(ACT_QUERY, 0, 1000, 500);
    // The far corners of the coordinate range, and a polygon spanning all of it.
    add_item(ACT_QUERY, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(ACT_QUERY, 0, 32'h8000_0000, 32'h8000_0000);
    add_item(ACT_WRITE, 0, 32'h8000_0000, 32'h8000_0000);
    add_item(ACT_WRITE, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(ACT_WRITE, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(ACT_WRITE, 63, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(ACT_WRITE, 3, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(ACT_QUERY, 0, 0, 0);
    add_item(ACT_QUERY, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_cfg(7'd3);
    add_item(ACT_QUERY, 0, -5, 7);
    add_cfg(7'd0);
    add_known(12345, -6789, 1'b0, 32'hFFFF_FFFF, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic int near_coord(input int center, input int span_log2);
    int span;
    span = 1 << span_log2;
    return center + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int        k, n, q, nq, span, cx, cy, idx;
    bit        full_range;
    out_item_t none;
    none         = '0;
    errors       = 0;
    items_sent   = 0;
    queries_sent = 0;
    answers_seen = 0;
    saturated_seen = 0;
    inside_seen  = 0;
    quiet        = 1'b0;
    shadow_count = '0;
    for (k = 0; k < NUM_ENTRIES; k++) begin
      shadow_x[k] = 0;
      shadow_y[k] = 0;
    end
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) set_vertex_count(directed_rows[r].cfg_val);
      else send_item(directed_rows[r].item, directed_rows[r].has_answer,
                     directed_rows[r].answer);
    end

    // Fill every table entry so that any vertex count, up to the largest, reads
    // only written entries.
    for (k = 0; k < NUM_ENTRIES; k++)
      send_item(make_item(ACT_WRITE, k, $urandom, $urandom), 1'b0, none);

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      // Mostly small polygons keep queries short; a few use the whole table or a
      // count past its end, and a few are empty.
      k = $urandom_range(0, 99);
      if (k < 4) n = 0;
      else if (k < 7) n = NUM_ENTRIES;
      else if (k < 9) n = $urandom_range(NUM_ENTRIES + 1, 127);
      else n = $urandom_range(3, 6);
      set_vertex_count(n[6:0]);

      full_range = ($urandom_range(0, 5) == 0);
      span = $urandom_range(4, 25);
      cx   = near_coord(0, 29);
      cy   = near_coord(0, 29);
      if (n > 0 && n <= 6) begin
        for (k = 0; k < n; k++) begin
          if (full_range)
            send_item(make_item(ACT_WRITE, k, $urandom, $urandom), 1'b0, none);
          else
            send_item(make_item(ACT_WRITE, k, near_coord(cx, span), near_coord(cy, span)),
                      1'b0, none);
        end
      end

      nq = (n > 6) ? 2 : $urandom_range(4, 10);
      for (q = 0; q < nq; q++) begin
        // Occasional rewrites of any entry: it stays written, so reads stay defined.
        if ($urandom_range(0, 4) == 0) begin
          idx = $urandom_range(0, NUM_ENTRIES - 1);
          if (idx < n && !full_range)
            send_item(make_item(ACT_WRITE, idx, near_coord(cx, span), near_coord(cy, span)),
                      1'b0, none);
          else
            send_item(make_item(ACT_WRITE, idx, $urandom, $urandom), 1'b0, none);
        end
        if (full_range || $urandom_range(0, 7) == 0)
          send_item(make_item(ACT_QUERY, $urandom, $urandom, $urandom), 1'b0, none);
        else
          send_item(make_item(ACT_QUERY, $urandom, near_coord(cx, span + 1),
                              near_coord(cy, span + 1)), 1'b0, none);
      end

      // In a window around the middle of the run the sender waits for the core to empty out.
      if (items_sent > RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 20)
        drain_core();
    end

    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d input transactions, %0d of them queries, over %0d cycles.",
             items_sent, queries_sent, cycles);
    $display("Checked %0d answers: %0d inside, %0d saturated or empty.",
             answers_seen, inside_seen, saturated_seen);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
